[design/ber_tlv_nesting_reader_assert.svh]
// Assertion macros shared by the ber_tlv_nesting_reader modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef BER_TLV_NESTING_READER_ASSERT_SVH
`define BER_TLV_NESTING_READER_ASSERT_SVH

// same-cycle implication
`define BTLV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btlv assertion failed");

// next-cycle implication
`define BTLV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btlv assertion failed");

`endif

[design/btlv_pkg.sv]
// Types and constants of the BER tag-length reader.
// Depends on nothing; used by the top module and btlv_core.
package btlv_pkg;

  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_LONG  = 2'd2
  } phase_t;

  localparam int unsigned LEN_LONG_BIT  = 7;
  localparam logic [6:0]  LEN_COUNT_MASK = 7'h7f;

  typedef struct packed {
    action_t    action;
    logic [7:0] stream_byte;
    logic [7:0] expected_tag;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic               error_flag;
    logic signed [31:0] remaining;
    logic [3:0]         level_count;
    logic               in_header;
    logic               content_valid;
    logic [7:0]         content_byte;
    logic [31:0]        position;
  } result_t;

endpackage

[design/ber_tlv_nesting_reader.sv]
// BER tag-length reader with a bounded stack of open nesting levels.
// Takes one word per clock while result_ready is held: input register, state
// update in btlv_core, result register. An accepted word waits in the input
// register until the result register is free. Each step reads and updates the
// reader state and the stack top. The level stack is a MAX_DEPTH-entry memory
// with registered read; it needs no clearing pass after reset. The user must
// write buffer_length through cfg_we/cfg_wdata only while idle; the block
// does not enforce this. Depends on btlv_pkg, btlv_core, the assertion macros.
`include "ber_tlv_nesting_reader_assert.svh"

module ber_tlv_nesting_reader #(
  parameter int MAX_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              item_valid,
  output logic              item_ready,
  input  btlv_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output btlv_pkg::result_t result
);
  import btlv_pkg::*;

  logic    stg_valid;
  item_t   stg_item;
  logic    advance;
  result_t step_result;

  assign advance    = stg_valid && (!result_valid || result_ready);
  assign item_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (item_ready) begin
      stg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_item <= '0;
    end else if (item_ready && item_valid) begin
      stg_item <= item;
    end
  end

  btlv_core #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (stg_item),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  `BTLV_ASSERT_NEXT(a_stg_hold, clk, rst, stg_valid && !advance,
                    stg_valid && $stable(stg_item))
  `BTLV_ASSERT_IMPLY(a_ok_no_err, clk, rst, result_valid && result.ok, !result.error_flag)
  `BTLV_ASSERT_IMPLY(a_content_idle, clk, rst, result_valid && result.content_valid,
                     !result.in_header)

endmodule

[design/btlv_stack.sv]
// Level stack memory: end offset of each open nesting level.
// One write port, one read port with registered read data; no package use.
module btlv_stack #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/btlv_core.sv]
// Reader state and single-pass step logic: position, header phase, stack top.
// Depends on btlv_pkg and btlv_stack; assertions from the shared macro header.
`include "ber_tlv_nesting_reader_assert.svh"

module btlv_core #(
  parameter int MAX_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             step,
  input  btlv_pkg::item_t  item,
  output btlv_pkg::result_t result
);
  import btlv_pkg::*;

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [31:0]   buffer_length;
  logic [31:0]   pos, pos_next, pos_inc;
  logic          err, err_next;
  phase_t        phase, phase_next;
  logic [6:0]    lbl, lbl_next, lbl_dec;
  logic [31:0]   pend, pend_next;
  logic [CW-1:0] lvl, lvl_next, lvl_eff, rd_idx;
  logic [31:0]   top_end, top_next;
  logic [31:0]   push_len, push_end, below_end;
  logic          push, full, byte_ok, success, cvalid;

  assign byte_ok  = pos < buffer_length;
  assign pos_inc  = pos + 32'd1;
  assign full     = lvl == CW'(MAX_DEPTH);
  assign lbl_dec  = (lbl != 7'd0) ? lbl - 7'd1 : 7'd0;
  assign push_end = pos_inc + push_len;

  always_comb begin
    pos_next   = pos;
    err_next   = err;
    phase_next = phase;
    lbl_next   = lbl;
    pend_next  = pend;
    lvl_next   = lvl;
    top_next   = top_end;
    success    = 1'b0;
    cvalid     = 1'b0;
    push       = 1'b0;
    push_len   = 32'd0;
    unique case (item.action)
      ACT_OPEN: begin
        if (phase != PH_IDLE || !byte_ok) begin
          err_next = 1'b1;
        end else begin
          pos_next = pos_inc;
          if (item.stream_byte != item.expected_tag || full) begin
            err_next = 1'b1;
          end else begin
            phase_next = PH_FIRST;
            success    = 1'b1;
          end
        end
      end
      ACT_BYTE: begin
        if (!byte_ok) begin
          err_next = 1'b1;
        end else begin
          pos_next = pos_inc;
          success  = 1'b1;
          unique case (phase)
            PH_FIRST: begin
              if (item.stream_byte[LEN_LONG_BIT]) begin
                lbl_next   = ((item.stream_byte[6:0] & LEN_COUNT_MASK) == 7'd0) ?
                             7'd1 : (item.stream_byte[6:0] & LEN_COUNT_MASK);
                pend_next  = 32'd0;
                phase_next = PH_LONG;
              end else begin
                push     = 1'b1;
                push_len = {24'd0, item.stream_byte};
              end
            end
            PH_LONG: begin
              pend_next = {pend[23:0], item.stream_byte};
              lbl_next  = lbl_dec;
              if (lbl_dec == 7'd0) begin
                push     = 1'b1;
                push_len = pend_next;
              end
            end
            default: begin
              cvalid = 1'b1;
            end
          endcase
        end
      end
      ACT_CLOSE: begin
        if (phase != PH_IDLE || lvl == '0 || top_end != pos) begin
          err_next = 1'b1;
        end else begin
          lvl_next = lvl - CW'(1);
          top_next = below_end;
          success  = 1'b1;
        end
      end
      ACT_NONE: begin
      end
    endcase
    if (push) begin
      phase_next = PH_IDLE;
      if (full) begin
        err_next = 1'b1;
      end else begin
        lvl_next = lvl + CW'(1);
        top_next = push_end;
      end
    end
  end

  assign lvl_eff = step ? lvl_next : lvl;
  assign rd_idx  = lvl_eff - CW'(2);

  btlv_stack #(
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (step && push && !full),
    .waddr (lvl[AW-1:0]),
    .wdata (push_end),
    .raddr (rd_idx[AW-1:0]),
    .rdata (below_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= 32'd0;
      pos           <= 32'd0;
      err           <= 1'b0;
      phase         <= PH_IDLE;
      lbl           <= 7'd0;
      pend          <= 32'd0;
      lvl           <= '0;
      top_end       <= 32'd0;
    end else begin
      if (cfg_we) begin
        buffer_length <= cfg_wdata;
      end
      if (step) begin
        pos     <= pos_next;
        err     <= err_next;
        phase   <= phase_next;
        lbl     <= lbl_next;
        pend    <= pend_next;
        lvl     <= lvl_next;
        top_end <= top_next;
      end
    end
  end

  always_comb begin
    result.ok            = success && !err_next;
    result.error_flag    = err_next;
    result.remaining     = (lvl_next == '0) ? '1 : $signed(top_next - pos_next);
    result.level_count   = 4'(lvl_next);
    result.in_header     = phase_next != PH_IDLE;
    result.content_valid = cvalid;
    result.content_byte  = cvalid ? item.stream_byte : 8'd0;
    result.position      = pos_next;
  end

  `BTLV_ASSERT_NEXT(a_err_sticky, clk, rst, err, err)
  `BTLV_ASSERT_IMPLY(a_lvl_bound, clk, rst, 1'b1, lvl <= CW'(MAX_DEPTH))
  `BTLV_ASSERT_NEXT(a_pos_hold, clk, rst, !step, pos == $past(pos) && lvl == $past(lvl))

endmodule
